### rtl/joint_pair_histogram_defines.svh
// Assertion macros for the joint pair histogram.
`ifndef JOINT_PAIR_HISTOGRAM_DEFINES_SVH
`define JOINT_PAIR_HISTOGRAM_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define JPH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("joint_pair_histogram: check failed");

// The consequent must hold in the cycle after the antecedent.
`define JPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("joint_pair_histogram: check failed");

`else

`define JPH_ASSERT_SAME(label, clk, rst, ante, cons)
`define JPH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/jph_pkg.sv
package jph_pkg;

   localparam int DEFAULT_MAX_BINS    = 16;
   localparam int DEFAULT_COUNT_WIDTH = 16;

   localparam int BINS_WIDTH  = 5;
   localparam int VALUE_WIDTH = 4;
   localparam int OUT_WIDTH   = 16;
   localparam int PAIRS_WIDTH = 16;

   localparam logic [BINS_WIDTH-1:0] BINS_RESET = 5'd16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]             operation;
      logic [VALUE_WIDTH-1:0] x_value;
      logic [VALUE_WIDTH-1:0] y_value;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]   bin_count;
      logic [PAIRS_WIDTH-1:0] pairs_total;
      logic                   out_of_range;
   } rsp_type;

   typedef enum logic [1:0] {
      ACT_ADD,
      ACT_READ,
      ACT_CLEAR,
      ACT_REJECT
   } act_type;

   typedef struct packed {
      act_type                act;
      logic [VALUE_WIDTH-1:0] x_value;
      logic [VALUE_WIDTH-1:0] y_value;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type push_data;
   } push_type;

   typedef struct packed {
      logic    full;
      logic    empty;
      cmd_type head;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

endpackage

### rtl/jph_front.sv
module jph_front #(
   parameter int MAX_BINS = jph_pkg::DEFAULT_MAX_BINS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  jph_pkg::req_type                    req_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jph_pkg::BINS_WIDTH-1:0]      csr_data,
   input  logic                                clearing,
   input  jph_pkg::queue_status_type           q_status,
   output jph_pkg::push_type                   q_push
);

   logic [jph_pkg::BINS_WIDTH-1:0] bins_in_use_ff;
   logic [jph_pkg::BINS_WIDTH-1:0] bins_in_use_in;
   logic                           x_ok;
   logic                           y_ok;
   jph_pkg::act_type               act;

   assign csr_ready      = 1'b1;
   assign bins_in_use_in = csr_valid ? csr_data : bins_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_in_use_ff <= jph_pkg::BINS_RESET;
      end else begin
         bins_in_use_ff <= bins_in_use_in;
      end
   end

   always_comb begin
      x_ok = ({1'b0, req_payload.x_value} < bins_in_use_ff) &&
             (32'(req_payload.x_value) < 32'(MAX_BINS));
      y_ok = ({1'b0, req_payload.y_value} < bins_in_use_ff) &&
             (32'(req_payload.y_value) < 32'(MAX_BINS));
      if (!(x_ok && y_ok)) begin
         act = jph_pkg::ACT_REJECT;
      end else begin
         unique case (req_payload.operation)
            jph_pkg::OP_ACCUMULATE: act = jph_pkg::ACT_ADD;
            jph_pkg::OP_READ_CLEAR: act = jph_pkg::ACT_CLEAR;
            jph_pkg::OP_READ:       act = jph_pkg::ACT_READ;
            default:                act = jph_pkg::ACT_READ;
         endcase
      end
   end

   assign req_stall                = q_status.full || clearing;
   assign q_push.push              = req_valid && !req_stall;
   assign q_push.push_data.act     = act;
   assign q_push.push_data.x_value = req_payload.x_value;
   assign q_push.push_data.y_value = req_payload.y_value;

endmodule

### rtl/jph_queue.sv
module jph_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  jph_pkg::push_type         q_push,
   input  logic                      pop,
   output jph_pkg::queue_status_type q_status
);

   jph_pkg::cmd_type                entry_ff [jph_pkg::QUEUE_DEPTH];
   logic [jph_pkg::QUEUE_PTR_W-1:0] wr_ff;
   logic [jph_pkg::QUEUE_PTR_W-1:0] wr_in;
   logic [jph_pkg::QUEUE_PTR_W-1:0] rd_ff;
   logic [jph_pkg::QUEUE_PTR_W-1:0] rd_in;
   logic [jph_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [jph_pkg::QUEUE_CNT_W-1:0] count_in;

   always_comb begin
      wr_in    = q_push.push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (q_push.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !q_push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ff] <= q_push.push_data;
      end
   end

   assign q_status.full  = count_ff == jph_pkg::QUEUE_CNT_W'(jph_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign q_status.head  = entry_ff[rd_ff];

endmodule

### rtl/jph_back.sv
module jph_back #(
   parameter int MAX_BINS    = jph_pkg::DEFAULT_MAX_BINS,
   parameter int COUNT_WIDTH = jph_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  jph_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output jph_pkg::rsp_type          rsp_payload
);

   localparam int DEPTH  = MAX_BINS * MAX_BINS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [COUNT_WIDTH-1:0] mem [DEPTH];

   jph_pkg::back_state_type           state_ff;
   jph_pkg::back_state_type           state_in;
   logic [ADDR_W-1:0]                 clr_ff;
   logic [ADDR_W-1:0]                 clr_in;
   jph_pkg::act_type                  act_ff;
   jph_pkg::act_type                  act_in;
   logic [ADDR_W-1:0]                 addr_ff;
   logic [ADDR_W-1:0]                 addr_in;
   logic [jph_pkg::PAIRS_WIDTH-1:0]   pairs_ff;
   logic [jph_pkg::PAIRS_WIDTH-1:0]   pairs_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   jph_pkg::rsp_type                  rsp_ff;
   jph_pkg::rsp_type                  rsp_in;
   logic [COUNT_WIDTH-1:0]            rd_data_ff;
   logic [COUNT_WIDTH-1:0]            bumped;
   logic [ADDR_W-1:0]                 head_addr;
   logic                              mem_re;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic [COUNT_WIDTH-1:0]            mem_wdata;

   assign head_addr = ADDR_W'(ADDR_W'(q_status.head.y_value) * ADDR_W'(MAX_BINS)) +
                      ADDR_W'(q_status.head.x_value);
   assign bumped    = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      act_in       = act_ff;
      addr_in      = addr_ff;
      pairs_in     = pairs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      unique case (state_ff)
         jph_pkg::BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = jph_pkg::BK_IDLE;
            end
         end
         jph_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               mem_re   = 1'b1;
               act_in   = q_status.head.act;
               addr_in  = head_addr;
               state_in = jph_pkg::BK_UPDATE;
            end
         end
         jph_pkg::BK_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in            = jph_pkg::BK_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.out_of_range = 1'b0;
               rsp_in.bin_count    = jph_pkg::OUT_WIDTH'(rd_data_ff);
               unique case (act_ff)
                  jph_pkg::ACT_ADD: begin
                     mem_we           = 1'b1;
                     mem_wdata        = bumped;
                     rsp_in.bin_count = jph_pkg::OUT_WIDTH'(bumped);
                     if (pairs_ff != '1) begin
                        pairs_in = pairs_ff + 1'b1;
                     end
                  end
                  jph_pkg::ACT_CLEAR: begin
                     mem_we = 1'b1;
                  end
                  jph_pkg::ACT_READ: begin
                     mem_we = 1'b0;
                  end
                  default: begin
                     rsp_in.bin_count    = '0;
                     rsp_in.out_of_range = 1'b1;
                  end
               endcase
               rsp_in.pairs_total = pairs_in;
            end
         end
         default: begin
            state_in = jph_pkg::BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jph_pkg::BK_CLEAR;
         clr_ff       <= '0;
         pairs_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pairs_ff     <= pairs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[head_addr];
      end
   end

   assign clearing    = state_ff == jph_pkg::BK_CLEAR;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/joint_pair_histogram.sv
// Joint histogram of (x, y) value pairs held in a MAX_BINS by MAX_BINS memory of saturating
// counts. After reset the block sweeps the memory to zero, one bin per cycle; req_stall
// stays high while it sweeps, while the csr port is always ready. Each accepted item gets
// one result, in order. An item enters a two-entry queue in the cycle it is accepted; the
// back end then pops it and reads its bin into a register, and in its update state writes
// the bin back if the item adds or clears and registers the result, holding there while
// the output is stalled. It pops no new item until that result is registered. Items whose
// x or y is not below bins_in_use (or MAX_BINS) touch no bin and return a zero count with
// out_of_range set.
`include "joint_pair_histogram_defines.svh"

module joint_pair_histogram #(
   parameter int MAX_BINS    = jph_pkg::DEFAULT_MAX_BINS,
   parameter int COUNT_WIDTH = jph_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  jph_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output jph_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jph_pkg::BINS_WIDTH-1:0] csr_data
);

   jph_pkg::push_type         q_push;
   jph_pkg::queue_status_type q_status;
   logic                      pop;
   logic                      clearing;
   logic                      rsp_rejected;

   jph_front #(
      .MAX_BINS(MAX_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .clearing   (clearing),
      .q_status   (q_status),
      .q_push     (q_push)
   );

   jph_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .pop     (pop),
      .q_status(q_status)
   );

   jph_back #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   assign rsp_rejected = rsp_valid && rsp_payload.out_of_range;

   `JPH_ASSERT_SAME(a_no_accept_while_clearing, clock, reset, clearing, req_stall)
   `JPH_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, !q_status.empty)
   `JPH_ASSERT_NEXT(a_push_fills_queue, clock, reset, q_push.push, !q_status.empty)
   `JPH_ASSERT_SAME(a_reject_reads_zero, clock, reset, rsp_rejected, rsp_payload.bin_count == '0)

endmodule

### verif/tb_hist_pkg.sv
package tb_hist_pkg;
   import jph_pkg::*;

   // Operation code three is not named in the design package; the block treats it as a read.
   localparam logic [1:0] OP_READ_SPARE = 2'd3;

   localparam int BIN_SIDE = DEFAULT_MAX_BINS;
   localparam logic [DEFAULT_COUNT_WIDTH-1:0] COUNT_TOP = '1;
   localparam logic [PAIRS_WIDTH-1:0] PAIRS_TOP = '1;

   class hist_scoreboard;
      logic [DEFAULT_COUNT_WIDTH-1:0] bin_counts [BIN_SIDE*BIN_SIDE];
      logic [PAIRS_WIDTH-1:0]         pairs_accumulated;
      logic [BINS_WIDTH-1:0]          bins_in_use;
      rsp_type                        expected_q [$];
      int                             errors;
      int                             items_seen;
      int                             results_seen;
      int                             rejected_items;

      function new();
         foreach (bin_counts[i]) bin_counts[i] = '0;
         pairs_accumulated = '0;
         bins_in_use = BINS_RESET;
         errors = 0;
         items_seen = 0;
         results_seen = 0;
         rejected_items = 0;
      endfunction

      function void set_bins(logic [BINS_WIDTH-1:0] setting);
         bins_in_use = setting;
      endfunction

      function int active_side();
         return (bins_in_use > BIN_SIDE) ? BIN_SIDE : int'(bins_in_use);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type item);
         rsp_type                        outcome;
         int                             side;
         int                             addr;
         logic [DEFAULT_COUNT_WIDTH-1:0] level;
         side = active_side();
         outcome = '0;
         items_seen++;
         if (int'(item.x_value) >= side || int'(item.y_value) >= side) begin
            outcome.out_of_range = 1'b1;
            rejected_items++;
         end else begin
            addr = int'(item.y_value) * BIN_SIDE + int'(item.x_value);
            level = bin_counts[addr];
            case (item.operation)
               OP_ACCUMULATE: begin
                  if (level != COUNT_TOP) level++;
                  bin_counts[addr] = level;
                  if (pairs_accumulated != PAIRS_TOP) pairs_accumulated++;
               end
               OP_READ_CLEAR: begin
                  bin_counts[addr] = '0;
               end
               default: begin
               end
            endcase
            outcome.bin_count = OUT_WIDTH'(level);
         end
         outcome.pairs_total = pairs_accumulated;
         expected_q.push_back(outcome);
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got,
                                  longint unsigned stamp);
         if (got !== want) begin
            errors++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d", stamp, label, want, got);
         end
      endfunction

      function void check_response(rsp_type got, longint unsigned stamp);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0d ns: result with no item waiting, expected none, actual %0d/%0d/%0d",
                     stamp, got.bin_count, got.pairs_total, got.out_of_range);
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         compare_field("bin_count", 32'(want.bin_count), 32'(got.bin_count), stamp);
         compare_field("pairs_total", 32'(want.pairs_total), 32'(got.pairs_total), stamp);
         compare_field("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range), stamp);
      endfunction
   endclass

endpackage

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jph_pkg::*;
   import tb_hist_pkg::*;

   localparam int QUIET_LIMIT     = 3000;
   localparam int RANDOM_ITEMS    = 360;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [BINS_WIDTH-1:0] csr_data;

   hist_scoreboard sb;
   int             send_idle_pct = 0;
   int             take_idle_pct = 0;
   int             quiet_cycles = 0;
   int             settings_used = 0;

   joint_pair_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < take_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload, $time);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0d ns: no item moved for %0d cycles", $time, quiet_cycles);
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(req_type item);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_bins(logic [BINS_WIDTH-1:0] setting);
      csr_valid <= 1'b1;
      csr_data <= setting;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_bins(setting);
      settings_used++;
   endtask

   function automatic logic [BINS_WIDTH-1:0] random_setting();
      if ($urandom_range(99) < 35) begin
         case ($urandom_range(3))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            default: return 5'd31;
         endcase
      end
      return BINS_WIDTH'($urandom_range(2, 15));
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      side;
      int      roll;
      side = sb.active_side();
      roll = $urandom_range(99);
      if (roll < 55) item.operation = OP_ACCUMULATE;
      else if (roll < 75) item.operation = OP_READ;
      else if (roll < 92) item.operation = OP_READ_CLEAR;
      else item.operation = OP_READ_SPARE;
      roll = $urandom_range(99);
      if (side == 0 || roll < 15) begin
         item.x_value = VALUE_WIDTH'($urandom_range(15));
         item.y_value = VALUE_WIDTH'($urandom_range(15));
      end else if (roll < 45) begin
         // A small corner of bins, at most two by two, gets a large share of pairs so that counts grow large.
         item.x_value = VALUE_WIDTH'($urandom_range((side < 2 ? side : 2) - 1));
         item.y_value = VALUE_WIDTH'($urandom_range((side < 2 ? side : 2) - 1));
      end else begin
         item.x_value = VALUE_WIDTH'($urandom_range(side - 1));
         item.y_value = VALUE_WIDTH'($urandom_range(side - 1));
      end
      return item;
   endfunction

   task automatic run_random(int count, int send_pct, int take_pct);
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 90 == 89) begin
            drain_results();
            write_bins(random_setting());
         end
         send_item(random_item());
      end
      drain_results();
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_data <= BINS_RESET;
      rsp_stall <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd0});
      send_item(req_type'{OP_ACCUMULATE, 4'd15, 4'd15});
      send_item(req_type'{OP_ACCUMULATE, 4'd15, 4'd0});
      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd15});
      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd0});
      send_item(req_type'{OP_READ, 4'd0, 4'd0});
      send_item(req_type'{OP_READ_SPARE, 4'd0, 4'd0});
      send_item(req_type'{OP_READ_CLEAR, 4'd0, 4'd0});
      send_item(req_type'{OP_READ, 4'd0, 4'd0});
      send_item(req_type'{OP_READ, 4'd15, 4'd15});
      send_item(req_type'{OP_READ_CLEAR, 4'd15, 4'd15});
      send_item(req_type'{OP_READ, 4'd5, 4'd10});
      drain_results();
      write_bins(5'd0);
      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd0});
      send_item(req_type'{OP_READ, 4'd0, 4'd0});
      send_item(req_type'{OP_READ_CLEAR, 4'd15, 4'd15});
      drain_results();
      write_bins(5'd31);
      send_item(req_type'{OP_ACCUMULATE, 4'd15, 4'd15});
      send_item(req_type'{OP_READ, 4'd15, 4'd15});
      drain_results();
      write_bins(5'd1);
      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd0});
      send_item(req_type'{OP_ACCUMULATE, 4'd1, 4'd0});
      send_item(req_type'{OP_ACCUMULATE, 4'd0, 4'd1});
      send_item(req_type'{OP_READ_CLEAR, 4'd0, 4'd0});
      drain_results();
      write_bins(5'd16);

      run_random(RANDOM_ITEMS, 26, 73);
      write_bins(5'd16);
      run_random(RANDOM_ITEMS, 73, 26);
      write_bins(BINS_WIDTH'($urandom_range(2, 15)));
      run_random(RANDOM_ITEMS, 0, 0);

      repeat (8) @(posedge clock);
      $display("Checked %0d results for %0d items, %0d out of range, under %0d bin settings.",
               sb.results_seen, sb.items_seen, sb.rejected_items, settings_used);
      $display("Ran three stall mixes and drained all results before each setting change.");
      if (sb.pending() != 0) begin
         $display("%0d ns: %0d expected results never arrived", $time, sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/jph_pkg.sv
rtl/jph_front.sv
rtl/jph_queue.sv
rtl/jph_back.sv
rtl/joint_pair_histogram.sv
verif/tb_hist_pkg.sv
verif/tb_top.sv
